@@ src/fdb3_pkg.sv @@
// shared coefficient table and helper function for the decimate-by-three fir
`timescale 1ns / 1ps
`default_nettype none
package fdb3_pkg;

	localparam int ROM_TAPS = 45;
	localparam int ROM_FRAC = 17;

	// hann-windowed sinc low-pass, q1.17
	localparam logic signed [ROM_FRAC:0] COEF_ROM [ROM_TAPS] = '{
		18'sd0,     18'sd8,     18'sd0,     -18'sd80,   -18'sd175,
		-18'sd93,   18'sd264,   18'sd639,   18'sd512,   -18'sd356,
		-18'sd1418, -18'sd1534, 18'sd0,     18'sd2403,  18'sd3510,
		18'sd1419,  -18'sd3382, -18'sd7325, -18'sd5644, 18'sd4103,
		18'sd19438, 18'sd33582, 18'sd39322, 18'sd33582, 18'sd19438,
		18'sd4103,  -18'sd5644, -18'sd7325, -18'sd3382, 18'sd1419,
		18'sd3510,  18'sd2403,  18'sd0,     -18'sd1534, -18'sd1418,
		-18'sd356,  18'sd512,   18'sd639,   18'sd264,   -18'sd93,
		-18'sd175,  -18'sd80,   18'sd0,     18'sd8,     18'sd0
	};

	// coefficient rescaled to q1.(coef_bits-1); taps past the table read as zero
	function automatic logic signed [31:0] coef_scaled(input int idx, input int coef_bits);
		logic signed [31:0] v;
		v = '0;
		if (idx >= 0 && idx < ROM_TAPS) begin
			v = 32'(COEF_ROM[idx]);
		end
		if (coef_bits >= ROM_FRAC + 1) begin
			v = v <<< (coef_bits - 1 - ROM_FRAC);
		end else begin
			// round half up
			v = (v + (32'sd1 <<< (ROM_FRAC - coef_bits))) >>> (ROM_FRAC + 1 - coef_bits);
		end
		return v;
	endfunction

endpackage
`default_nettype wire

@@ src/fdb3_cell.sv @@
// one tap of the transposed fir chain: multiply the new sample and add the neighbor's sum
`timescale 1ns / 1ps
`default_nettype none
module fdb3_cell #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS = 18,
	parameter int ACC_BITS = 48,
	parameter logic signed [COEF_BITS-1:0] COEF = '0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       shift_en,
	input  wire logic signed [SAMPLE_BITS-1:0] x,
	input  wire logic signed [ACC_BITS-1:0]    sum_in,
	output logic signed [ACC_BITS-1:0]         sum_q
);

	logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod;

	assign prod = x * COEF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (shift_en) begin
			sum_q <= sum_in + ACC_BITS'(prod);
		end
	end

endmodule
`default_nettype wire

@@ src/fdb3_out.sv @@
// rounding, saturation and output register of the decimated stream
`timescale 1ns / 1ps
`default_nettype none
module fdb3_out #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS = 18,
	parameter int ACC_BITS = 48,
	parameter int DATA_BITS = 24
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire logic signed [ACC_BITS-1:0] sum,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [DATA_BITS-1:0]            m_tdata
);

	localparam int FRAC = COEF_BITS - 1;
	localparam int SH_BITS = ACC_BITS + 1 - FRAC;
	localparam logic signed [SH_BITS-1:0] SAT_HI = SH_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SH_BITS-1:0] SAT_LO = -SAT_HI - SH_BITS'(1);

	logic signed [ACC_BITS:0]  rounded;
	logic signed [ACC_BITS:0]  shifted;
	logic signed [SH_BITS-1:0] scaled;
	logic [SAMPLE_BITS-1:0]    sat_val;

	// round half up, then drop the fraction
	assign rounded = (ACC_BITS + 1)'(sum) + ((ACC_BITS + 1)'(1) <<< (FRAC - 1));
	assign shifted = rounded >>> FRAC;
	assign scaled = shifted[SH_BITS-1:0];

	always_comb begin
		priority if (scaled > SAT_HI) begin
			sat_val = SAT_HI[SAMPLE_BITS-1:0];
		end else if (scaled < SAT_LO) begin
			sat_val = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			sat_val = scaled[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= DATA_BITS'(sat_val);
		end
	end

endmodule
`default_nettype wire

@@ src/fir_decimator_by_three_unit.sv @@
// top level of the decimate-by-three windowed-sinc fir
`timescale 1ns / 1ps
`default_nettype none
// Decimating low-pass FIR, 48 kHz in and 16 kHz out. Every accepted input sample is
// broadcast to a transposed chain of TAP_COUNT cells, each holding one coefficient,
// one multiplier and one partial-sum register, so one sample is taken every clock unless
// the input stalls as below. The phase counter starts at zero after reset; the sample
// taken at phase zero produces one result, which lands in the sum register of cell
// zero as that sample is taken, is rounded and saturated into the output register once
// that register is free and is shown on m_tvalid from then on. Input stalls only when
// a finished sum cannot move on because the output register is still held by the sink.
// The cell registers clear at reset, which is the cleared delay line.
module fir_decimator_by_three_unit #(
	parameter int TAP_COUNT = 45,
	parameter int DECIMATION = 3,
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS = 18
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample_in
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]      m_tdata   // sample_out
);

	import fdb3_pkg::*;

	localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + $clog2(TAP_COUNT);
	localparam int PHASE_BITS = $clog2(DECIMATION);

	logic signed [SAMPLE_BITS-1:0] x;
	logic signed [ACC_BITS-1:0]    sums [TAP_COUNT+1];
	logic [PHASE_BITS-1:0]         phase_q;
	logic                          sum_valid_q;
	logic                          accept;
	logic                          move;

	assign x = s_tdata[SAMPLE_BITS-1:0];
	assign sums[TAP_COUNT] = '0;

	// the full sum sits in cell zero until the output register takes it
	assign move = sum_valid_q && (!m_tvalid || m_tready);
	assign s_tready = !sum_valid_q || move;
	assign accept = s_tvalid && s_tready;

	for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
		localparam logic signed [COEF_BITS-1:0] C_K =
			COEF_BITS'(coef_scaled(TAP_COUNT - 1 - k, COEF_BITS));
		fdb3_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.COEF_BITS  (COEF_BITS),
			.ACC_BITS   (ACC_BITS),
			.COEF       (C_K)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(accept),
			.x       (x),
			.sum_in  (sums[k+1]),
			.sum_q   (sums[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			sum_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				sum_valid_q <= (phase_q == '0);
				if (phase_q == PHASE_BITS'(DECIMATION - 1)) begin
					phase_q <= '0;
				end else begin
					phase_q <= phase_q + PHASE_BITS'(1);
				end
			end else if (move) begin
				sum_valid_q <= 1'b0;
			end
		end
	end

	fdb3_out #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS),
		.ACC_BITS   (ACC_BITS),
		.DATA_BITS  (DATA_BITS)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (move),
		.sum     (sums[0]),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// self-checking testbench for the decimate-by-three fir unit
`timescale 1ns / 1ps
module testbench;

	localparam int SAMPLE_MAX = 8388607;
	localparam int SAMPLE_MIN = -8388608;
	localparam int TAPS = 45;
	localparam int HISTORY = TAPS - 1;
	localparam int DECIM = 3;
	localparam int RANDOM_ITEMS = 1000;

	// q1.17 low-pass taps, oldest sample first
	localparam int LOWPASS_TAPS [TAPS] = '{
		0,     8,     0,   -80,  -175,   -93,   264,   639,   512,  -356,
		-1418, -1534,     0,  2403,  3510,  1419, -3382, -7325, -5644,  4103,
		19438, 33582, 39322, 33582, 19438,  4103, -5644, -7325, -3382,  1419,
		3510,  2403,     0, -1534, -1418,  -356,   512,   639,   264,   -93,
		-175,   -80,     0,     8,     0
	};

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;  // sample_in
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;  // sample_out

	logic [23:0] pending_samples [$];
	logic [23:0] filtered_expected [$];
	logic signed [23:0] history [HISTORY] = '{default: '0};
	int unsigned dec_phase = 0;
	int samples_queued = 0;
	int samples_sent = 0;
	int samples_accepted = 0;
	int total_samples = 0;
	int mismatch_count = 0;
	bit in_accepted = 1'b0;
	bit sink_hold = 1'b0;

	fir_decimator_by_three_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		$display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// filter the history and the new sample when the phase is zero, then shift the new sample in
	task automatic filter_and_decimate(input logic signed [23:0] x);
		longint acc;
		longint rounded;
		acc = 0;
		if (dec_phase == 0) begin
			for (int t = 0; t < HISTORY; t++) begin
				acc += longint'(history[t]) * longint'(LOWPASS_TAPS[t]);
			end
			acc += longint'(x) * longint'(LOWPASS_TAPS[TAPS - 1]);
			// floor shift after adding half gives round half up
			rounded = (acc + (64'sd1 <<< 16)) >>> 17;
			if (rounded > SAMPLE_MAX) begin
				rounded = SAMPLE_MAX;
			end
			if (rounded < SAMPLE_MIN) begin
				rounded = SAMPLE_MIN;
			end
			filtered_expected.push_back(rounded[23:0]);
		end
		for (int t = 0; t + 1 < HISTORY; t++) begin
			history[t] = history[t + 1];
		end
		history[HISTORY - 1] = x;
		dec_phase = (dec_phase + 1 >= DECIM) ? 0 : dec_phase + 1;
	endtask

	function automatic void queue_sample(input int v);
		pending_samples.push_back(v[23:0]);
		samples_queued++;
	endfunction

	// history values that line up with the tap signs, so the sum runs near or out of range
	function automatic void queue_saturating_run();
		int mag;
		bit negate;
		int v;
		while (samples_queued % DECIM != 1) begin
			queue_sample(int'($urandom));
		end
		mag = $urandom_range(1) ? SAMPLE_MAX : int'($urandom_range(SAMPLE_MAX, 5000000));
		negate = $urandom_range(1);
		for (int t = 0; t < HISTORY; t++) begin
			if (LOWPASS_TAPS[t] == 0) begin
				v = int'($urandom);
			end else if ((LOWPASS_TAPS[t] > 0) != negate) begin
				v = mag;
			end else begin
				v = -mag - 1;
			end
			queue_sample(v);
		end
		queue_sample(int'($urandom));
	endfunction

	function automatic int sender_idle_pct();
		int mode;
		mode = (samples_sent * 4) / total_samples;
		return (mode == 1) ? 50 : (mode == 3) ? 37 : 0;
	endfunction

	function automatic int receiver_stall_pct();
		int mode;
		mode = (samples_sent * 4) / total_samples;
		return (mode == 2) ? 50 : (mode == 3) ? 37 : 0;
	endfunction

	// source side: hold the transaction until taken, otherwise maybe offer the next one
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_accepted) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
				s_tdata <= pending_samples.pop_front();
				s_tvalid <= 1'b1;
				samples_sent++;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side
	always @(negedge clk) begin
		if (!arst_n || sink_hold) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_stall_pct());
		end
	end

	always @(posedge clk) begin
		in_accepted = arst_n && s_tvalid && s_tready;
		if (in_accepted) begin
			filter_and_decimate(s_tdata);
			samples_accepted++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (filtered_expected.size() == 0) begin
				report_mismatch("sample_out with none pending", m_tdata, '0);
			end else if (m_tdata !== filtered_expected[0]) begin
				report_mismatch("sample_out", m_tdata, filtered_expected.pop_front());
			end else begin
				void'(filtered_expected.pop_front());
			end
		end
	end

	// long sink stall while the source keeps offering, so the input backs up
	initial begin
		wait (samples_accepted >= 60);
		@(posedge clk);
		sink_hold = 1'b1;
		repeat (300) @(posedge clk);
		sink_hold = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("** fir_decimator_by_three_unit: FAILED **");
		$finish;
	end

	initial begin
		int kind;
		int burst;
		int level;
		// extremes and bit patterns
		queue_sample(SAMPLE_MAX);
		queue_sample(SAMPLE_MIN);
		queue_sample(0);
		queue_sample(-1);
		queue_sample(1);
		queue_sample(24'h555555);
		queue_sample(24'haaaaaa);
		queue_sample(24'h800001);
		queue_sample(24'h7ffffe);
		for (int i = 0; i < 12; i++) begin
			queue_sample((i % 2) ? SAMPLE_MIN : SAMPLE_MAX);
		end
		queue_sample(0);
		queue_sample(0);
		queue_sample(SAMPLE_MAX);
		while (samples_queued < RANDOM_ITEMS + 24) begin
			kind = $urandom_range(9);
			burst = $urandom_range(1, 20);
			case (kind)
				5: begin
					for (int i = 0; i < burst; i++) begin
						case ($urandom_range(3))
							0: queue_sample(SAMPLE_MAX);
							1: queue_sample(SAMPLE_MIN);
							2: queue_sample(0);
							default: queue_sample(-1);
						endcase
					end
				end
				6, 7: begin
					queue_saturating_run();
				end
				8: begin
					for (int i = 0; i < burst; i++) begin
						queue_sample(int'($urandom_range(511)) - 256);
					end
				end
				9: begin
					level = int'($urandom);
					for (int i = 0; i < 30; i++) begin
						queue_sample(level);
					end
				end
				default: begin
					for (int i = 0; i < burst; i++) begin
						queue_sample(int'($urandom));
					end
				end
			endcase
		end
		total_samples = samples_queued;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (samples_accepted == total_samples);
		wait (filtered_expected.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("** fir_decimator_by_three_unit: PASSED **");
		end else begin
			$display("** fir_decimator_by_three_unit: FAILED **");
		end
		$finish;
	end

endmodule
